// ===== hw/rtl/ptl_pkg.sv =====
`timescale 1ns / 1ps
package ptl_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int MAX_RESULTS = 16;
    localparam int IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
    localparam int RCNT_W = $clog2(MAX_RESULTS + 1);
    localparam int REQ_DEPTH = 2;
    localparam int RES_DEPTH = 4;

    typedef logic [2:0] t_op;
    localparam t_op OP_ADD      = 3'd0;
    localparam t_op OP_REMOVE   = 3'd1;
    localparam t_op OP_FIND_MAC = 3'd2;
    localparam t_op OP_FIND_ID  = 3'd3;
    localparam t_op OP_CONTACT  = 3'd4;
    localparam t_op OP_TICK     = 3'd5;
    localparam t_op OP_LIST     = 3'd6;
    localparam t_op OP_CLEAR    = 3'd7;

    localparam logic [1:0] EV_PLAIN   = 2'd0;
    localparam logic [1:0] EV_OFFLINE = 2'd1;
    localparam logic [1:0] EV_ONLINE  = 2'd2;

    typedef struct packed {
        t_op         op;
        logic [47:0] mac;
        logic [7:0]  eid;
        logic [7:0]  dtype;
        logic        onl;
        logic [31:0] now;
        logic        by_mac;  // search keyed on MAC
        logic        walk;    // walks every entry (tick, list)
    } t_req;

    typedef struct packed {
        logic        ok;
        logic [7:0]  id;
        logic [47:0] mac;
        logic [7:0]  typ;
        logic        onl;
        logic [1:0]  kind;
        logic        last;
    } t_res;

endpackage

// ===== hw/rtl/ptl_front.sv =====
`timescale 1ns / 1ps
module ptl_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    output logic             o_full,
    input  logic [2:0]       i_req_type,
    input  logic [47:0]      i_mac,
    input  logic [7:0]       i_entry_id,
    input  logic [7:0]       i_dev_type,
    input  logic             i_online,
    input  logic [31:0]      i_time_ms,
    output logic             o_req_valid,
    output ptl_pkg::t_req    o_req,
    input  logic             i_req_take
);
    import ptl_pkg::*;

    localparam int PTR_W = (REQ_DEPTH > 1) ? $clog2(REQ_DEPTH) : 1;
    localparam int QCNT_W = $clog2(REQ_DEPTH + 1);

    t_req              r_mem [REQ_DEPTH];
    logic [PTR_W-1:0]  r_wr, r_rd;
    logic [QCNT_W-1:0] r_cnt;
    t_req              cls;
    logic              wr_en, rd_en;

    // classify the request on entry
    always_comb begin
        cls.op     = t_op'(i_req_type);
        cls.mac    = i_mac;
        cls.eid    = i_entry_id;
        cls.dtype  = i_dev_type;
        cls.onl    = i_online;
        cls.now    = i_time_ms;
        cls.by_mac = (cls.op == OP_ADD) || (cls.op == OP_FIND_MAC) || (cls.op == OP_CONTACT);
        cls.walk   = (cls.op == OP_TICK) || (cls.op == OP_LIST);
    end

    assign o_full      = (r_cnt == QCNT_W'(REQ_DEPTH));
    assign o_req_valid = (r_cnt != '0);
    assign o_req       = r_mem[r_rd];
    assign wr_en       = i_push && !o_full;
    assign rd_en       = i_req_take && o_req_valid;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr] <= cls;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_en) begin
                r_wr <= (r_wr == PTR_W'(REQ_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (rd_en) begin
                r_rd <= (r_rd == PTR_W'(REQ_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + QCNT_W'(wr_en) - QCNT_W'(rd_en);
        end
    end

endmodule

// ===== hw/rtl/ptl_resq.sv =====
`timescale 1ns / 1ps
module ptl_resq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr,
    input  ptl_pkg::t_res i_res,
    output logic          o_full,
    output logic          o_empty,
    output ptl_pkg::t_res o_res,
    input  logic          i_pop
);
    import ptl_pkg::*;

    localparam int PTR_W = (RES_DEPTH > 1) ? $clog2(RES_DEPTH) : 1;
    localparam int QCNT_W = $clog2(RES_DEPTH + 1);

    t_res              r_mem [RES_DEPTH];
    logic [PTR_W-1:0]  r_wr, r_rd;
    logic [QCNT_W-1:0] r_cnt;
    logic              wr_en, rd_en;

    assign o_full  = (r_cnt == QCNT_W'(RES_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_res   = r_mem[r_rd];
    assign wr_en   = i_wr && !o_full;
    assign rd_en   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr] <= i_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_en) begin
                r_wr <= (r_wr == PTR_W'(RES_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (rd_en) begin
                r_rd <= (r_rd == PTR_W'(RES_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + QCNT_W'(wr_en) - QCNT_W'(rd_en);
        end
    end

endmodule

// ===== hw/rtl/ptl_engine.sv =====
`timescale 1ns / 1ps
module ptl_engine (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [31:0]   i_cfg_wdata,
    input  logic          i_req_valid,
    input  ptl_pkg::t_req i_req,
    output logic          o_req_take,
    output logic          o_res_wr,
    output ptl_pkg::t_res o_res,
    input  logic          i_res_full
);
    import ptl_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCAN  = 3'd1;
    localparam logic [2:0] ST_ACT   = 3'd2;
    localparam logic [2:0] ST_SHIFT = 3'd3;
    localparam logic [2:0] ST_FLUSH = 3'd4;

    typedef struct packed {
        logic [47:0] mac;
        logic [7:0]  id;
        logic [7:0]  typ;
        logic        onl;
        logic [31:0] last;
    } t_entry;

    t_entry             r_tab [MAX_ENTRIES];
    logic [2:0]         r_state, n_state;
    t_req               r_req, n_req;
    logic [CNT_W-1:0]   r_idx, n_idx;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               r_found, n_found;
    logic [RCNT_W-1:0]  r_n, n_n;
    logic               r_pend_v, n_pend_v;
    t_res               r_pend, n_pend;
    logic [7:0]         r_next_id, n_next_id;
    logic [31:0]        r_interval, r_limit;

    logic [CNT_W-1:0]   idx_up;
    logic [IDX_W-1:0]   rd_addr, wr_addr;
    t_entry             e, wr_e;
    logic               wr_en;
    logic               hit;
    logic [31:0]        age;
    logic               over, chg, rep;
    logic [7:0]         new_id, take_id, id_after;
    logic [8:0]         id_inc;

    function automatic t_res mk_entry(t_entry x, logic [1:0] kind, logic last);
        t_res r;
        r.ok   = 1'b1;
        r.id   = x.id;
        r.mac  = x.mac;
        r.typ  = x.typ;
        r.onl  = x.onl;
        r.kind = kind;
        r.last = last;
        return r;
    endfunction

    function automatic t_res mk_plain(logic ok);
        t_res r;
        r      = '0;
        r.ok   = ok;
        r.last = 1'b1;
        return r;
    endfunction

    assign idx_up  = r_idx + 1'b1;
    assign rd_addr = (r_state == ST_SHIFT) ? idx_up[IDX_W-1:0] : r_idx[IDX_W-1:0];
    assign e       = r_tab[rd_addr];
    assign hit     = r_req.by_mac ? (e.mac == r_req.mac) : (e.id == r_req.eid);
    assign age     = r_req.now - e.last;
    assign over    = age > r_limit;
    assign chg     = (r_interval != '0) && (over ? e.onl : !e.onl);
    assign rep     = (r_req.op == OP_TICK) ? chg : (e.typ == r_req.dtype);
    assign id_inc  = {1'b0, r_next_id} + 9'd1;
    assign take_id = r_next_id;
    assign new_id  = (id_inc > 9'(MAX_ENTRIES)) ? 8'd1 : id_inc[7:0];
    assign id_after = (r_req.eid != '0) ? r_req.eid : ((e.id != '0) ? e.id : take_id);

    always_comb begin
        n_state   = r_state;
        n_req     = r_req;
        n_idx     = r_idx;
        n_count   = r_count;
        n_found   = r_found;
        n_n       = r_n;
        n_pend_v  = r_pend_v;
        n_pend    = r_pend;
        n_next_id = r_next_id;
        o_req_take = 1'b0;
        o_res_wr  = 1'b0;
        o_res     = r_pend;
        wr_en     = 1'b0;
        wr_addr   = r_idx[IDX_W-1:0];
        wr_e      = e;
        unique case (r_state)
            ST_IDLE: begin
                if (i_req_valid) begin
                    o_req_take = 1'b1;
                    n_req      = i_req;
                    n_idx      = '0;
                    n_n        = '0;
                    n_pend_v   = 1'b0;
                    n_found    = 1'b0;
                    n_state    = (i_req.op == OP_CLEAR) ? ST_ACT : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_idx == r_count) begin
                    n_state = r_req.walk ? ST_FLUSH : ST_ACT;
                end else if (!r_req.walk) begin
                    // stop on the first match and hold its index
                    if (hit) begin
                        n_found = 1'b1;
                        n_state = ST_ACT;
                    end else begin
                        n_idx = idx_up;
                    end
                end else if (!i_res_full) begin
                    if (r_req.op == OP_TICK && chg) begin
                        wr_en     = 1'b1;
                        wr_e.onl  = !e.onl;
                    end
                    if (rep && r_n < RCNT_W'(MAX_RESULTS)) begin
                        // emit the held result, hold the new one
                        o_res_wr = r_pend_v;
                        o_res    = r_pend;
                        n_pend_v = 1'b1;
                        n_pend   = mk_entry(wr_e, (r_req.op == OP_TICK) ?
                                   (over ? EV_OFFLINE : EV_ONLINE) : EV_PLAIN, 1'b0);
                        n_n      = r_n + 1'b1;
                    end
                    n_idx = idx_up;
                end
            end
            ST_FLUSH: begin
                if (!i_res_full) begin
                    o_res_wr = 1'b1;
                    if (r_pend_v) begin
                        o_res      = r_pend;
                        o_res.last = 1'b1;
                    end else begin
                        o_res = mk_plain((r_req.op == OP_TICK) && (r_interval != '0));
                    end
                    n_state = ST_IDLE;
                end
            end
            ST_ACT: begin
                if (!i_res_full) begin
                    o_res_wr = 1'b1;
                    n_state  = ST_IDLE;
                    o_res    = mk_plain(1'b0);
                    unique case (r_req.op)
                        OP_ADD: begin
                            wr_en     = 1'b1;
                            wr_e.typ  = r_req.dtype;
                            wr_e.onl  = r_req.onl;
                            wr_e.last = r_req.now;
                            if (r_found) begin
                                wr_e.id = id_after;
                                if (r_req.eid == '0 && e.id == '0) begin
                                    n_next_id = new_id;
                                end
                                o_res = mk_entry(wr_e, EV_PLAIN, 1'b1);
                            end else if (r_count >= CNT_W'(MAX_ENTRIES)) begin
                                wr_en = 1'b0;
                            end else begin
                                wr_addr   = r_count[IDX_W-1:0];
                                wr_e.mac  = r_req.mac;
                                wr_e.id   = take_id;
                                n_next_id = new_id;
                                n_count   = r_count + 1'b1;
                                o_res     = mk_entry(wr_e, EV_PLAIN, 1'b1);
                            end
                        end
                        OP_REMOVE: begin
                            if (r_found) begin
                                o_res   = mk_entry(e, EV_PLAIN, 1'b1);
                                n_state = ST_SHIFT;
                            end
                        end
                        OP_CONTACT: begin
                            if (r_found) begin
                                wr_en     = 1'b1;
                                wr_e.onl  = 1'b1;
                                wr_e.last = r_req.now;
                                o_res = mk_entry(wr_e, e.onl ? EV_PLAIN : EV_ONLINE, 1'b1);
                            end
                        end
                        OP_CLEAR: begin
                            n_count   = '0;
                            n_next_id = 8'd1;
                            o_res     = mk_plain(1'b1);
                        end
                        default: begin
                            if (r_found) begin
                                o_res = mk_entry(e, EV_PLAIN, 1'b1);
                            end
                        end
                    endcase
                end
            end
            ST_SHIFT: begin
                // pull the later entries down one slot
                if (idx_up >= r_count) begin
                    n_count = r_count - 1'b1;
                    n_state = ST_IDLE;
                end else begin
                    wr_en = 1'b1;
                    n_idx = idx_up;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_tab[wr_addr] <= wr_e;
        end
        r_req  <= n_req;
        r_pend <= n_pend;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_idx      <= '0;
            r_count    <= '0;
            r_found    <= 1'b0;
            r_n        <= '0;
            r_pend_v   <= 1'b0;
            r_next_id  <= 8'd1;
            r_interval <= '0;
            r_limit    <= '0;
        end else begin
            r_state   <= n_state;
            r_idx     <= n_idx;
            r_count   <= n_count;
            r_found   <= n_found;
            r_n       <= n_n;
            r_pend_v  <= n_pend_v;
            r_next_id <= n_next_id;
            if (i_cfg_we) begin
                r_interval <= i_cfg_wdata;
                r_limit    <= i_cfg_wdata + {i_cfg_wdata[30:0], 1'b0};
            end
        end
    end

endmodule

// ===== hw/rtl/peer_table_with_liveness.sv =====
`timescale 1ns / 1ps
// Sequence: a lookup item scans from entry 0 and stops at the first match or at the fill.
// Remove then holds the engine while it moves each later entry down one slot to compact the table;
// tick and list walk every entry up to the fill.
// Throughput: one item at a time; one entry per cycle; tick and list stall while results are full.
// Reset: synchronous, active low; empties both queues, sets the fill to 0,
// the next id to 1 and the heartbeat interval to 0.
module peer_table_with_liveness (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request side
    input  logic        push,
    output logic        full,
    input  logic [2:0]  i_req_type,
    input  logic [47:0] i_mac,
    input  logic [7:0]  i_entry_id,
    input  logic [7:0]  i_dev_type,
    input  logic        i_online,
    input  logic [31:0] i_time_ms,
    // result side
    output logic        empty,
    input  logic        pop,
    output logic        o_done_ok,
    output logic [7:0]  o_result_id,
    output logic [47:0] o_result_mac,
    output logic [7:0]  o_result_type,
    output logic        o_result_online,
    output logic [1:0]  o_event_kind,
    output logic        o_is_last,
    // heartbeat interval register
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata
);
    import ptl_pkg::*;

    logic req_valid, req_take, res_wr, res_full;
    t_req req;
    t_res res_in, res_out;

    // Front: take each request transaction, classify it, and hold it in a
    // short queue so the caller can line up two requests behind a table walk.
    ptl_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_req_type  (i_req_type),
        .i_mac       (i_mac),
        .i_entry_id  (i_entry_id),
        .i_dev_type  (i_dev_type),
        .i_online    (i_online),
        .i_time_ms   (i_time_ms),
        .o_req_valid (req_valid),
        .o_req       (req),
        .i_req_take  (req_take)
    );

    // Back: the table and its sequencer. Scan one entry per cycle, then
    // update, compact or sweep; a tick or list walk and each result write wait on a full result queue.
    ptl_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req_valid (req_valid),
        .i_req       (req),
        .o_req_take  (req_take),
        .o_res_wr    (res_wr),
        .o_res       (res_in),
        .i_res_full  (res_full)
    );

    // Result queue: hold finished results until the consumer pops them.
    ptl_resq u_resq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (res_wr),
        .i_res   (res_in),
        .o_full  (res_full),
        .o_empty (empty),
        .o_res   (res_out),
        .i_pop   (pop)
    );

    assign o_done_ok       = res_out.ok;
    assign o_result_id     = res_out.id;
    assign o_result_mac    = res_out.mac;
    assign o_result_type   = res_out.typ;
    assign o_result_online = res_out.onl;
    assign o_event_kind    = res_out.kind;
    assign o_is_last       = res_out.last;

    // the engine never writes into a full result queue
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(res_wr && res_full))
        else $error("result written while queue full");

    // the engine takes a request only when one is waiting
    a_take_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_take |-> req_valid)
        else $error("request taken from empty queue");

    // both queues come out of reset empty
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queues not empty after reset");

endmodule
